FILE: hw/rtl/led_matrix_command_and_scan_unit_macros.svh
// ----------------------------------------------------------------------------
// LED matrix command and scan unit assertion macros
// Shared concurrent assertion forms for the checker of the unit.
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_COMMAND_AND_SCAN_UNIT_MACROS_SVH
`define LED_MATRIX_COMMAND_AND_SCAN_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LMCS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LMCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Like the one above, but also checked while reset is applied.
`define LMCS_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/lmcs_pkg.sv
// ----------------------------------------------------------------------------
// LED matrix command and scan package
// Types, command codes and default sizes shared by the unit and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lmcs_pkg;

    localparam int ROW_COUNT_DEF    = 7;
    localparam int COLUMN_COUNT_DEF = 5;

    localparam logic ITEM_BYTE = 1'b0;
    localparam logic ITEM_TICK = 1'b1;

    localparam logic PHASE_COMMAND = 1'b0;
    localparam logic PHASE_DATA    = 1'b1;

    localparam logic [7:0] CMD_NONE       = 8'h00;
    localparam logic [7:0] CMD_ROW_FIRST  = 8'h01;
    localparam logic [7:0] CMD_ROW_LAST   = 8'h07;
    localparam logic [7:0] CMD_GLYPH      = 8'h08;
    localparam logic [7:0] CMD_CLEAR      = 8'h09;
    localparam logic [7:0] CMD_DISPLAY    = 8'h10;
    localparam logic [7:0] CMD_LOAD_FIRST = 8'h20;
    localparam logic [7:0] CMD_LOAD_LAST  = 8'h2F;
    localparam logic [7:0] CMD_SAVE_FIRST = 8'h30;
    localparam logic [7:0] CMD_SAVE_LAST  = 8'h3F;

    typedef enum logic [1:0] {
        STORE_NONE = 2'd0,
        STORE_LOAD = 2'd1,
        STORE_SAVE = 2'd2
    } t_store_req;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } t_in_req;

    typedef struct packed {
        logic       pixel_lit;
        logic [2:0] drive_row;
        logic [2:0] drive_column;
        logic       glyph_request;
        logic [7:0] glyph_code;
        logic [1:0] store_request;
        logic [3:0] store_slot;
    } t_out_req;

endpackage

FILE: hw/rtl/lmcs_chan_if.sv
// ----------------------------------------------------------------------------
// LED matrix command and scan channel
// Valid and ready handshake carrying one request of the given type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lmcs_chan_if #(
    parameter type T = logic
);

    logic valid;
    logic ready;
    T     payload;

    modport source (
        output valid,
        input  ready,
        output payload
    );

    modport sink (
        input  valid,
        output ready,
        input  payload
    );

endinterface

FILE: hw/rtl/led_matrix_command_and_scan_unit.sv
// ----------------------------------------------------------------------------
// LED matrix command and scan unit
// Command decoder and one-pixel multiplex scan for a dot-matrix display.
//
// Requests on i_in carry either a received serial byte or a scan tick. Bytes
// come in pairs: the first is latched as a command, the second is its data
// and executes the pair (row write, glyph request, clear, display on or off,
// image load or save request). Scan ticks step the scan one pixel while the
// display is on and drive the lit pixel, if any.
// Every accepted request yields exactly one request on o_out, which shows
// the drive after that step and one-step glyph and store request pulses.
// A request is registered on entry and decoded against the display state, which
// writes the result register: the result is offered once it has passed the input
// register and then the result register, and one request can be accepted every
// cycle while o_out does not stall.
// When o_out stalls, the result register holds, the input register fills and
// then i_in.ready drops until the result is taken; nothing is dropped.
// Reset blanks all rows, turns the display off, darkens the drive, resets
// the scan position and the byte pairing, and empties both registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module led_matrix_command_and_scan_unit #(
    parameter int ROW_COUNT    = lmcs_pkg::ROW_COUNT_DEF,
    parameter int COLUMN_COUNT = lmcs_pkg::COLUMN_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lmcs_chan_if.sink   i_in,
    lmcs_chan_if.source o_out
);

    import lmcs_pkg::*;

    localparam int RW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int CW = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;

    logic                    r_in_valid;
    t_in_req                 r_in;
    logic                    r_out_valid;
    t_out_req                r_out;
    t_out_req                n_out;

    logic [COLUMN_COUNT-1:0] r_rows [ROW_COUNT];
    logic [COLUMN_COUNT-1:0] n_rows [ROW_COUNT];
    logic                    r_byte_phase;
    logic                    n_byte_phase;
    logic [7:0]              r_cmd;
    logic [7:0]              n_cmd;
    logic [CW-1:0]           r_scan_col;
    logic [CW-1:0]           n_scan_col;
    logic [RW-1:0]           r_scan_row;
    logic [RW-1:0]           n_scan_row;
    logic                    r_enabled;
    logic                    n_enabled;
    logic                    r_drv_lit;
    logic                    n_drv_lit;
    logic [2:0]              r_drv_row;
    logic [2:0]              n_drv_row;
    logic [2:0]              r_drv_col;
    logic [2:0]              n_drv_col;

    logic                    w_advance;
    logic                    w_in_accept;
    logic [COLUMN_COUNT-1:0] w_row_bits;
    logic [COLUMN_COUNT-1:0] w_row_shift;
    logic [CW-1:0]           w_bitpos;
    logic                    w_pixel;
    logic [2:0]              w_wr_row;
    logic                    w_wr_ok;

    assign w_advance   = r_in_valid && (!r_out_valid || o_out.ready);
    assign w_in_accept = i_in.valid && i_in.ready;
    assign i_in.ready  = !r_in_valid || w_advance;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    always_comb begin
        w_row_bits = '0;
        for (int i = 0; i < ROW_COUNT; i++) begin
            if (r_scan_row == RW'(i)) begin
                w_row_bits = r_rows[i];
            end
        end
        w_bitpos    = CW'(COLUMN_COUNT - 1) - r_scan_col;
        w_row_shift = w_row_bits >> w_bitpos;
        w_pixel     = w_row_shift[0] && (32'(r_scan_col) < COLUMN_COUNT)
                      && (32'(r_scan_row) < ROW_COUNT);
        w_wr_row    = 3'(r_cmd - CMD_ROW_FIRST);
        w_wr_ok     = (32'(w_wr_row) < ROW_COUNT);
    end

    always_comb begin
        n_rows       = r_rows;
        n_byte_phase = r_byte_phase;
        n_cmd        = r_cmd;
        n_scan_col   = r_scan_col;
        n_scan_row   = r_scan_row;
        n_enabled    = r_enabled;
        n_drv_lit    = r_drv_lit;
        n_drv_row    = r_drv_row;
        n_drv_col    = r_drv_col;
        n_out        = '0;

        if (r_in.command == ITEM_TICK) begin
            if (r_enabled) begin
                n_drv_lit = w_pixel;
                n_drv_row = w_pixel ? (3'(ROW_COUNT - 1) - 3'(r_scan_row)) : 3'd0;
                n_drv_col = w_pixel ? 3'(w_bitpos) : 3'd0;
                if (r_scan_col >= CW'(COLUMN_COUNT - 1)) begin
                    n_scan_col = '0;
                    if (r_scan_row >= RW'(ROW_COUNT - 1)) begin
                        n_scan_row = '0;
                    end else begin
                        n_scan_row = r_scan_row + 1'b1;
                    end
                end else begin
                    n_scan_col = r_scan_col + 1'b1;
                end
            end
        end else if (r_byte_phase == PHASE_COMMAND) begin
            n_cmd        = r_in.data_byte;
            n_byte_phase = PHASE_DATA;
        end else begin
            n_byte_phase = PHASE_COMMAND;
            n_cmd        = CMD_NONE;
            if (r_cmd inside {[CMD_ROW_FIRST:CMD_ROW_LAST]}) begin
                for (int i = 0; i < ROW_COUNT; i++) begin
                    if (w_wr_ok && (w_wr_row == 3'(i))) begin
                        n_rows[i] = r_in.data_byte[COLUMN_COUNT-1:0];
                    end
                end
            end else if (r_cmd == CMD_GLYPH) begin
                if (r_in.data_byte != 8'd0) begin
                    n_out.glyph_request = 1'b1;
                    n_out.glyph_code    = r_in.data_byte;
                end
            end else if (r_cmd == CMD_CLEAR) begin
                for (int i = 0; i < ROW_COUNT; i++) begin
                    n_rows[i] = '0;
                end
            end else if (r_cmd == CMD_DISPLAY) begin
                if (r_in.data_byte[0]) begin
                    n_enabled = 1'b1;
                end else begin
                    n_enabled = 1'b0;
                    n_drv_lit = 1'b0;
                    n_drv_row = 3'd0;
                    n_drv_col = 3'd0;
                end
            end else if (r_cmd inside {[CMD_LOAD_FIRST:CMD_LOAD_LAST]}) begin
                n_out.store_request = STORE_LOAD;
                n_out.store_slot    = r_cmd[3:0];
            end else if (r_cmd inside {[CMD_SAVE_FIRST:CMD_SAVE_LAST]}) begin
                n_out.store_request = STORE_SAVE;
                n_out.store_slot    = r_cmd[3:0];
            end
        end

        n_out.pixel_lit    = n_drv_lit;
        n_out.drive_row    = n_drv_row;
        n_out.drive_column = n_drv_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_byte_phase <= PHASE_COMMAND;
            r_cmd        <= CMD_NONE;
            r_scan_col   <= '0;
            r_scan_row   <= '0;
            r_enabled    <= 1'b0;
            r_drv_lit    <= 1'b0;
            r_drv_row    <= 3'd0;
            r_drv_col    <= 3'd0;
            for (int i = 0; i < ROW_COUNT; i++) begin
                r_rows[i] <= '0;
            end
        end else begin
            if (w_in_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid  <= 1'b1;
                r_byte_phase <= n_byte_phase;
                r_cmd        <= n_cmd;
                r_scan_col   <= n_scan_col;
                r_scan_row   <= n_scan_row;
                r_enabled    <= n_enabled;
                r_drv_lit    <= n_drv_lit;
                r_drv_row    <= n_drv_row;
                r_drv_col    <= n_drv_col;
                r_rows       <= n_rows;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in <= i_in.payload;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: hw/rtl/lmcs_checker.sv
// ----------------------------------------------------------------------------
// LED matrix command and scan checker
// Port-level assertions on the unit's handshakes, bound into the unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "led_matrix_command_and_scan_unit_macros.svh"

module lmcs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input lmcs_pkg::t_out_req i_out_payload
);

    // An empty unit must present no result right after reset.
    `LMCS_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !i_out_valid,
        "result after reset")

    // A stalled result must stay offered and unchanged.
    `LMCS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_payload), "stalled result changed")

    // An accepted request is offered in the next cycle once the old result is taken.
    `LMCS_ASSERT_NEXT(a_latency, i_clk, i_rst_n,
        (i_in_valid && i_in_ready) ##1 i_out_ready, i_out_valid,
        "result missing after request")

    // Input back-pressure only comes from a stalled, waiting result.
    `LMCS_ASSERT_SAME(a_ready_cause, i_clk, i_rst_n, !i_in_ready,
        i_out_valid && !i_out_ready, "input stalled without output stall")

endmodule

bind led_matrix_command_and_scan_unit lmcs_checker u_lmcs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_payload (o_out.payload)
);

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// LED matrix command and scan unit testbench
// Drives byte pairs, lone bytes and scan ticks into the unit, mostly under
// random idling on both channels, and checks every result against a
// cycle-free model of the drive and of the glyph and image store request pulses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import lmcs_pkg::*;

class matrix_drive_model;

    localparam int ROWS = ROW_COUNT_DEF;
    localparam int COLS = COLUMN_COUNT_DEF;

    logic [COLS-1:0] row_image [ROWS];
    logic            byte_phase;
    logic [7:0]      cmd_latch;
    int              scan_col;
    int              scan_row;
    logic            display_on;
    logic            lit;
    logic [2:0]      lit_row;
    logic [2:0]      lit_col;
    t_out_req        expected_drives [$];
    int              mismatches;

    function new();
        foreach (row_image[i]) row_image[i] = '0;
        byte_phase = PHASE_COMMAND;
        cmd_latch  = CMD_NONE;
        scan_col   = 0;
        scan_row   = 0;
        display_on = 1'b0;
        lit        = 1'b0;
        lit_row    = '0;
        lit_col    = '0;
        mismatches = 0;
    endfunction

    function int pending();
        return expected_drives.size();
    endfunction

    function void accept_request(t_in_req req);
        t_out_req res;
        int       bitpos;
        res = '0;
        if (req.command == ITEM_TICK) begin
            if (display_on) begin
                bitpos  = COLS - 1 - scan_col;
                lit     = 1'b0;
                lit_row = '0;
                lit_col = '0;
                if (row_image[scan_row][bitpos]) begin
                    lit     = 1'b1;
                    lit_row = 3'(ROWS - 1 - scan_row);
                    lit_col = 3'(bitpos);
                end
                scan_col++;
                if (scan_col >= COLS) begin
                    scan_col = 0;
                    scan_row++;
                    if (scan_row >= ROWS) scan_row = 0;
                end
            end
        end else if (byte_phase == PHASE_COMMAND) begin
            cmd_latch  = req.data_byte;
            byte_phase = PHASE_DATA;
        end else begin
            byte_phase = PHASE_COMMAND;
            if (cmd_latch >= CMD_ROW_FIRST && cmd_latch <= CMD_ROW_LAST) begin
                if (int'(cmd_latch) - 1 < ROWS) begin
                    row_image[cmd_latch - 1] = req.data_byte[COLS-1:0];
                end
            end else if (cmd_latch == CMD_GLYPH) begin
                if (req.data_byte != 8'h00) begin
                    res.glyph_request = 1'b1;
                    res.glyph_code    = req.data_byte;
                end
            end else if (cmd_latch == CMD_CLEAR) begin
                foreach (row_image[i]) row_image[i] = '0;
            end else if (cmd_latch == CMD_DISPLAY) begin
                display_on = req.data_byte[0];
                if (!req.data_byte[0]) begin
                    lit     = 1'b0;
                    lit_row = '0;
                    lit_col = '0;
                end
            end else if (cmd_latch >= CMD_LOAD_FIRST && cmd_latch <= CMD_LOAD_LAST) begin
                res.store_request = STORE_LOAD;
                res.store_slot    = cmd_latch[3:0];
            end else if (cmd_latch >= CMD_SAVE_FIRST && cmd_latch <= CMD_SAVE_LAST) begin
                res.store_request = STORE_SAVE;
                res.store_slot    = cmd_latch[3:0];
            end
            cmd_latch = CMD_NONE;
        end
        res.pixel_lit    = lit;
        res.drive_row    = lit_row;
        res.drive_column = lit_col;
        expected_drives.push_back(res);
    endfunction

    task report_mismatch(string what, int got, int want);
        $display("%0t: %s is %0h, expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task check_drive(t_out_req got);
        t_out_req want;
        if (expected_drives.size() == 0) begin
            report_mismatch("result without a request", 1, 0);
            return;
        end
        want = expected_drives.pop_front();
        if (got.pixel_lit !== want.pixel_lit)
            report_mismatch("pixel_lit", got.pixel_lit, want.pixel_lit);
        if (got.drive_row !== want.drive_row)
            report_mismatch("drive_row", got.drive_row, want.drive_row);
        if (got.drive_column !== want.drive_column)
            report_mismatch("drive_column", got.drive_column, want.drive_column);
        if (got.glyph_request !== want.glyph_request)
            report_mismatch("glyph_request", got.glyph_request, want.glyph_request);
        if (got.glyph_code !== want.glyph_code)
            report_mismatch("glyph_code", got.glyph_code, want.glyph_code);
        if (got.store_request !== want.store_request)
            report_mismatch("store_request", got.store_request, want.store_request);
        if (got.store_slot !== want.store_slot)
            report_mismatch("store_slot", got.store_slot, want.store_slot);
    endtask

endclass

module tb_top;

    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 200;

    logic i_clk;
    logic i_rst_n;
    int   in_idle_pct  = 17;
    int   out_idle_pct = 54;
    int   quiet_cycles = 0;
    int   requests_sent = 0;

    matrix_drive_model model;

    lmcs_chan_if #(.T(t_in_req))  in_ch ();
    lmcs_chan_if #(.T(t_out_req)) out_ch ();

    led_matrix_command_and_scan_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        out_ch.ready  = 1'b0;
    end

    always @(negedge i_clk) begin
        out_ch.ready <= i_rst_n && ($urandom_range(99) >= out_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            model.check_drive(out_ch.payload);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("tb_top failed");
        $finish;
    end

    task automatic send_item(input logic kind, input logic [7:0] value);
        t_in_req req;
        req.command   = kind;
        req.data_byte = value;
        while ($urandom_range(99) < in_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= req;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        model.accept_request(req);
        requests_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_pair(input logic [7:0] cmd, input logic [7:0] value);
        send_item(ITEM_BYTE, cmd);
        send_item(ITEM_BYTE, value);
    endtask

    task automatic send_tick();
        send_item(ITEM_TICK, 8'($urandom_range(255)));
    endtask

    task automatic send_random_item();
        int          pick;
        logic [7:0]  value;
        pick  = $urandom_range(99);
        value = 8'($urandom_range(255));
        if (pick < 45) begin
            send_tick();
        end else if (pick < 60) begin
            send_pair(8'($urandom_range(CMD_ROW_LAST, CMD_ROW_FIRST)), value);
        end else if (pick < 64) begin
            send_pair(CMD_GLYPH, ($urandom_range(3) == 0) ? 8'h00 : value);
        end else if (pick < 66) begin
            send_pair(CMD_CLEAR, value);
        end else if (pick < 74) begin
            value[0] = ($urandom_range(3) != 0);
            send_pair(CMD_DISPLAY, value);
        end else if (pick < 80) begin
            send_pair(8'($urandom_range(CMD_SAVE_LAST, CMD_LOAD_FIRST)), value);
        end else if (pick < 88) begin
            send_pair(8'($urandom_range(255)), value);
        end else begin
            send_item(ITEM_BYTE, value);
        end
    endtask

    task automatic run_directed();
        send_tick();
        send_pair(CMD_DISPLAY, 8'h01);
        send_pair(CMD_ROW_FIRST, 8'hFF);
        send_pair(CMD_ROW_LAST, 8'h15);
        send_tick();
        send_tick();
        send_pair(CMD_GLYPH, 8'h00);
        send_pair(CMD_GLYPH, 8'hFF);
        send_pair(CMD_LOAD_FIRST, 8'h00);
        send_pair(CMD_SAVE_LAST, 8'hA5);
        send_pair(8'hFF, 8'h5A);
        send_pair(CMD_DISPLAY, 8'hFE);
        send_tick();
        send_pair(CMD_CLEAR, 8'h00);
    endtask

    task automatic run_random_phase(input int sender_pct, input int receiver_pct);
        int target;
        in_idle_pct  = sender_pct;
        out_idle_pct = receiver_pct;
        target       = requests_sent + PHASE_ITEMS;
        while (requests_sent < target) send_random_item();
    endtask

    initial begin
        model   = new();
        i_rst_n = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        run_random_phase(17, 54);
        run_random_phase(54, 17);
        run_random_phase(0, 0);
        in_ch.valid <= 1'b0;
        while (model.pending() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (model.mismatches == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
